[src/mbt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_pkg
// shared types, character codes and lookup functions of the markup tokenizer
// ---------------------------------------------------------------------------
package mbt_pkg;

	localparam int TOK_BITS = 17;
	localparam int DOC_BITS = 21;
	localparam int POS_BITS = DOC_BITS + 1;
	localparam int CNT_BITS = TOK_BITS + 1;
	localparam int OFFSET_BITS_DEF = 21;
	localparam int LENGTH_BITS_DEF = 17;
	localparam int QDEPTH = 4;
	localparam int QA_BITS = $clog2(QDEPTH);

	localparam logic [TOK_BITS-1:0] TOK_CAP_RESET = 17'd65536;
	localparam logic [DOC_BITS-1:0] DOC_CAP_RESET = 21'd1048576;

	// register select by paddr[2]
	localparam logic REG_MAX_TOKEN = 1'b0;
	localparam logic REG_MAX_INPUT = 1'b1;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	typedef enum logic [4:0] {
		M_TEXT_IDLE, M_TEXT_RUN, M_LT, M_BANG, M_BANG_DASH, M_COMMENT,
		M_CLOSE_START, M_CLOSE_NAME, M_CLOSE_WS, M_TAG_NAME, M_IN_TAG,
		M_SLASH, M_ATTR_NAME, M_ATTR_WS, M_ATTR_EQ, M_ATTR_VAL, M_RAW
	} mode_t;

	typedef enum logic [3:0] {
		K_TEXT, K_COMMENT, K_OPEN_START, K_OPEN_END, K_SELF_CLOSE,
		K_CLOSE, K_ATTR, K_EOF, K_ERROR
	} kind_t;

	// zero also fills the code field of non-error tokens
	typedef enum logic [4:0] {
		E_INPUT_CAP, E_BAD_LT, E_TEXT_CAP, E_COMMENT_CAP, E_COMMENT_OPEN,
		E_TAG_NAME_CAP, E_CLOSE_NO_NAME, E_CLOSE_NAME_CAP, E_CLOSE_NO_GT,
		E_TAG_OPEN, E_STRAY_SLASH, E_NO_ATTR_NAME, E_ATTR_NAME_CAP, E_NO_EQ,
		E_NO_QUOTE, E_LT_IN_VALUE, E_VALUE_CAP, E_VALUE_OPEN, E_RAW_CAP,
		E_RAW_OPEN
	} err_t;

	typedef enum logic [1:0] {
		RAW_NONE, RAW_STYLE, RAW_SCRIPT
	} raw_t;

	typedef struct packed {
		kind_t               kind;
		logic [POS_BITS-1:0] start;
		logic [POS_BITS-1:0] len;
		logic [CNT_BITS-1:0] nlen;
		logic [POS_BITS-1:0] vstart;
		logic [CNT_BITS-1:0] vlen;
		err_t                code;
		logic                last;
	} tok_t;

	typedef struct packed {
		logic [TOK_BITS-1:0] max_tok;
		logic [DOC_BITS-1:0] max_doc;
	} caps_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic logic is_nstart(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic is_nchar(input logic [7:0] c);
		return is_nstart(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] style_ch(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h73;
			3'd1: r = 8'h74;
			3'd2: r = 8'h79;
			3'd3: r = 8'h6C;
			3'd4: r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] script_ch(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h73;
			3'd1: r = 8'h63;
			3'd2: r = 8'h72;
			3'd3: r = 8'h69;
			3'd4: r = 8'h70;
			3'd5: r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// letter k of "</style" or "</script"
	function automatic logic [7:0] closer_ch(input raw_t kind, input logic [3:0] k);
		logic [7:0] r;
		logic [3:0] j;
		j = k - 4'd2;
		if (k == 4'd0) r = CH_LT;
		else if (k == 4'd1) r = CH_SLASH;
		else if (kind == RAW_SCRIPT) r = script_ch(j[2:0]);
		else r = style_ch(j[2:0]);
		return r;
	endfunction

endpackage

[src/mbt_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_front
// byte scanner: takes one byte request per cycle while there is room, keeps
// the scan state and hands up to two finished tokens to the result queue
// ---------------------------------------------------------------------------
module mbt_front #(
	parameter int OFFSET_BITS = mbt_pkg::OFFSET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     byte_value,
	input  logic           end_marker,
	input  mbt_pkg::caps_t caps,
	input  logic           room,
	output logic           push0,
	output logic           push1,
	output mbt_pkg::tok_t  tok0,
	output mbt_pkg::tok_t  tok1
);
	import mbt_pkg::*;

	localparam logic [63:0] OMASK = (64'd1 << OFFSET_BITS) - 64'd1;

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d, start_q, start_d, vorg_q, vorg_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d, aname_q, aname_d;
	logic                sq_q, sq_d, halt_q, halt_d;
	logic [1:0]          match_q, match_d, dash_q, dash_d;
	raw_t                rawk_q, rawk_d;
	logic [3:0]          prog_q, prog_d;

	tok_t e1, e2;
	logic e1v, e2v;
	logic accept;

	function automatic tok_t mk(input kind_t k, input logic [POS_BITS-1:0] s,
		input logic [POS_BITS-1:0] l, input logic [CNT_BITS-1:0] nl,
		input logic [POS_BITS-1:0] vs, input logic [CNT_BITS-1:0] vl);
		tok_t t;
		t.kind = k;
		t.start = s;
		t.len = l;
		t.nlen = nl;
		t.vstart = vs;
		t.vlen = vl;
		t.code = E_INPUT_CAP;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic tok_t mk_err(input err_t code, input logic [POS_BITS-1:0] s,
		input logic [POS_BITS-1:0] l);
		tok_t t;
		t = mk(K_ERROR, s, l, '0, '0, '0);
		t.code = code;
		return t;
	endfunction

	assign in_ready = room;
	assign accept = in_valid && room;

	// next state and token generation
	always_comb begin
		logic [7:0]          c, lc;
		logic [POS_BITS-1:0] p, p1, mtp, cst;
		logic [CNT_BITS-1:0] mt, sc;
		logic [3:0]          clen;
		logic [63:0]         seen;
		logic                tag_do;
		logic [1:0]          tag_sm;
		logic                keep0, keep1;

		c = byte_value;
		lc = to_lower(byte_value);
		p = pos_q;
		p1 = pos_q + POS_BITS'(1);
		mt = CNT_BITS'(caps.max_tok);
		mtp = POS_BITS'(caps.max_tok);
		sc = cnt_q;
		clen = (rawk_q == RAW_SCRIPT) ? 4'd8 : 4'd7;
		cst = p1 - POS_BITS'(clen);
		seen = 64'(p1);
		tag_do = 1'b0;
		tag_sm = match_q;
		keep0 = 1'b0;
		keep1 = 1'b0;

		mode_d = mode_q;
		pos_d = pos_q;
		start_d = start_q;
		vorg_d = vorg_q;
		cnt_d = cnt_q;
		aname_d = aname_q;
		sq_d = sq_q;
		match_d = match_q;
		dash_d = dash_q;
		rawk_d = rawk_q;
		prog_d = prog_q;
		halt_d = halt_q;
		e1 = '0;
		e2 = '0;
		e1v = 1'b0;
		e2v = 1'b0;

		if (accept) begin
			if (end_marker) begin
				if (!halt_q) begin
					unique case (mode_q)
						M_TEXT_RUN: begin
							e1 = mk(K_TEXT, start_q, POS_BITS'(cnt_q), '0, '0, '0);
							e1v = 1'b1;
							e2 = mk(K_EOF, p, '0, '0, '0, '0);
							e2v = 1'b1;
						end
						M_LT, M_BANG, M_BANG_DASH: begin
							e2 = mk_err(E_BAD_LT, start_q, '0);
							e2v = 1'b1;
						end
						M_COMMENT: begin
							if (cnt_q + CNT_BITS'(dash_q) > mt)
								e2 = mk_err(E_COMMENT_CAP, start_q, mtp + POS_BITS'(5));
							else
								e2 = mk_err(E_COMMENT_OPEN, start_q, p - start_q);
							e2v = 1'b1;
						end
						M_CLOSE_START: begin
							e2 = mk_err(E_CLOSE_NO_NAME, start_q, POS_BITS'(2));
							e2v = 1'b1;
						end
						M_CLOSE_NAME, M_CLOSE_WS: begin
							e2 = mk_err(E_CLOSE_NO_GT, start_q, p - start_q);
							e2v = 1'b1;
						end
						M_TAG_NAME: begin
							e1 = mk(K_OPEN_START, start_q, POS_BITS'(cnt_q) + POS_BITS'(1),
								cnt_q, '0, '0);
							e1v = 1'b1;
							e2 = mk_err(E_TAG_OPEN, p, '0);
							e2v = 1'b1;
						end
						M_IN_TAG: begin
							e2 = mk_err(E_TAG_OPEN, p, '0);
							e2v = 1'b1;
						end
						M_SLASH: begin
							e2 = mk_err(E_STRAY_SLASH, start_q, '0);
							e2v = 1'b1;
						end
						M_ATTR_NAME, M_ATTR_WS: begin
							e2 = mk_err(E_NO_EQ, start_q, p - start_q);
							e2v = 1'b1;
						end
						M_ATTR_EQ: begin
							e2 = mk_err(E_NO_QUOTE, start_q, p - start_q);
							e2v = 1'b1;
						end
						M_ATTR_VAL: begin
							e2 = mk_err(E_VALUE_OPEN, start_q, p - start_q);
							e2v = 1'b1;
						end
						M_RAW: begin
							if (cnt_q + CNT_BITS'(prog_q) > mt)
								e2 = mk_err(E_RAW_CAP, start_q, mtp + POS_BITS'(1));
							else
								e2 = mk_err(E_RAW_OPEN, start_q, p - start_q);
							e2v = 1'b1;
						end
						default: begin
							e2 = mk(K_EOF, p, '0, '0, '0, '0);
							e2v = 1'b1;
						end
					endcase
				end
				mode_d = M_TEXT_IDLE;
				pos_d = '0;
				start_d = '0;
				vorg_d = '0;
				cnt_d = '0;
				aname_d = '0;
				sq_d = 1'b0;
				match_d = '0;
				dash_d = '0;
				rawk_d = RAW_NONE;
				prog_d = '0;
				halt_d = 1'b0;
			end else if (halt_q) begin
				halt_d = 1'b1;
			end else if (p >= POS_BITS'(caps.max_doc)) begin
				e2 = mk_err(E_INPUT_CAP, '0, (seen > OMASK) ? POS_BITS'(OMASK) : p1);
				e2v = 1'b1;
				halt_d = 1'b1;
			end else begin
				unique case (mode_q)
					M_TEXT_IDLE: begin
						start_d = p;
						if (c == CH_LT) mode_d = M_LT;
						else begin
							cnt_d = CNT_BITS'(1);
							mode_d = M_TEXT_RUN;
							if (CNT_BITS'(1) > mt) begin
								e2 = mk_err(E_TEXT_CAP, p, POS_BITS'(1));
								e2v = 1'b1;
							end
						end
					end
					M_TEXT_RUN: begin
						if (c == CH_LT) begin
							e1 = mk(K_TEXT, start_q, POS_BITS'(cnt_q), '0, '0, '0);
							e1v = 1'b1;
							start_d = p;
							mode_d = M_LT;
						end else begin
							sc = cnt_q + CNT_BITS'(1);
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_TEXT_CAP, start_q, POS_BITS'(sc));
								e2v = 1'b1;
							end
						end
					end
					M_LT: begin
						if (c == CH_BANG) mode_d = M_BANG;
						else if (c == CH_SLASH) mode_d = M_CLOSE_START;
						else if (is_nstart(c)) begin
							match_d = {lc == script_ch(3'd0), lc == style_ch(3'd0)};
							cnt_d = CNT_BITS'(1);
							mode_d = M_TAG_NAME;
							if (CNT_BITS'(1) > mt) begin
								e2 = mk_err(E_TAG_NAME_CAP, start_q, POS_BITS'(2));
								e2v = 1'b1;
							end
						end else begin
							e2 = mk_err(E_BAD_LT, start_q, '0);
							e2v = 1'b1;
						end
					end
					M_BANG: begin
						if (c == CH_DASH) mode_d = M_BANG_DASH;
						else begin
							e2 = mk_err(E_BAD_LT, start_q, '0);
							e2v = 1'b1;
						end
					end
					M_BANG_DASH: begin
						if (c == CH_DASH) begin
							mode_d = M_COMMENT;
							vorg_d = p1;
							cnt_d = '0;
							dash_d = '0;
						end else begin
							e2 = mk_err(E_BAD_LT, start_q, '0);
							e2v = 1'b1;
						end
					end
					M_COMMENT: begin
						if (c == CH_GT && dash_q == 2'd2) begin
							e1 = mk(K_COMMENT, start_q, p1 - start_q, '0, vorg_q, cnt_q);
							e1v = 1'b1;
							dash_d = '0;
							mode_d = M_TEXT_IDLE;
						end else begin
							if (c == CH_DASH) begin
								if (dash_q < 2'd2) dash_d = dash_q + 2'd1;
								else sc = cnt_q + CNT_BITS'(1);
							end else begin
								sc = cnt_q + CNT_BITS'(dash_q) + CNT_BITS'(1);
								dash_d = '0;
							end
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_COMMENT_CAP, start_q, mtp + POS_BITS'(5));
								e2v = 1'b1;
							end
						end
					end
					M_CLOSE_START: begin
						if (is_nstart(c)) begin
							cnt_d = CNT_BITS'(1);
							mode_d = M_CLOSE_NAME;
							if (CNT_BITS'(1) > mt) begin
								e2 = mk_err(E_CLOSE_NAME_CAP, start_q, POS_BITS'(3));
								e2v = 1'b1;
							end
						end else begin
							e2 = mk_err(E_CLOSE_NO_NAME, start_q, POS_BITS'(2));
							e2v = 1'b1;
						end
					end
					M_CLOSE_NAME, M_CLOSE_WS: begin
						if (mode_q == M_CLOSE_NAME && is_nchar(c)) begin
							sc = cnt_q + CNT_BITS'(1);
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_CLOSE_NAME_CAP, start_q,
									POS_BITS'(sc) + POS_BITS'(2));
								e2v = 1'b1;
							end
						end else if (is_ws(c)) mode_d = M_CLOSE_WS;
						else if (c == CH_GT) begin
							e1 = mk(K_CLOSE, start_q, p1 - start_q, cnt_q, '0, '0);
							e1v = 1'b1;
							mode_d = M_TEXT_IDLE;
						end else begin
							e2 = mk_err(E_CLOSE_NO_GT, start_q, p - start_q);
							e2v = 1'b1;
						end
					end
					M_TAG_NAME: begin
						if (is_nchar(c)) begin
							keep0 = (cnt_q < CNT_BITS'(5)) && lc == style_ch(cnt_q[2:0]);
							keep1 = (cnt_q < CNT_BITS'(6)) && lc == script_ch(cnt_q[2:0]);
							match_d = match_q & {keep1, keep0};
							sc = cnt_q + CNT_BITS'(1);
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_TAG_NAME_CAP, start_q,
									POS_BITS'(sc) + POS_BITS'(1));
								e2v = 1'b1;
							end
						end else begin
							e1 = mk(K_OPEN_START, start_q, POS_BITS'(cnt_q) + POS_BITS'(1),
								cnt_q, '0, '0);
							e1v = 1'b1;
							if (match_q[0] && cnt_q == CNT_BITS'(5)) tag_sm = 2'b01;
							else if (match_q[1] && cnt_q == CNT_BITS'(6)) tag_sm = 2'b10;
							else tag_sm = 2'b00;
							match_d = tag_sm;
							mode_d = M_IN_TAG;
							tag_do = 1'b1;
						end
					end
					M_IN_TAG: begin
						tag_do = 1'b1;
					end
					M_SLASH: begin
						if (c == CH_GT) begin
							e1 = mk(K_SELF_CLOSE, start_q, POS_BITS'(2), '0, '0, '0);
							e1v = 1'b1;
							match_d = '0;
							mode_d = M_TEXT_IDLE;
						end else begin
							e2 = mk_err(E_STRAY_SLASH, start_q, '0);
							e2v = 1'b1;
						end
					end
					M_ATTR_NAME: begin
						if (is_nchar(c)) begin
							sc = cnt_q + CNT_BITS'(1);
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_ATTR_NAME_CAP, start_q, POS_BITS'(sc));
								e2v = 1'b1;
							end
						end else if (is_ws(c) || c == CH_EQ) begin
							aname_d = cnt_q;
							mode_d = (c == CH_EQ) ? M_ATTR_EQ : M_ATTR_WS;
						end else begin
							e2 = mk_err(E_NO_EQ, start_q, p - start_q);
							e2v = 1'b1;
						end
					end
					M_ATTR_WS: begin
						if (!is_ws(c)) begin
							if (c == CH_EQ) mode_d = M_ATTR_EQ;
							else begin
								e2 = mk_err(E_NO_EQ, start_q, p - start_q);
								e2v = 1'b1;
							end
						end
					end
					M_ATTR_EQ: begin
						if (!is_ws(c)) begin
							if (c == CH_DQ || c == CH_SQ) begin
								sq_d = (c == CH_SQ);
								vorg_d = p1;
								cnt_d = '0;
								mode_d = M_ATTR_VAL;
							end else begin
								e2 = mk_err(E_NO_QUOTE, start_q, p - start_q);
								e2v = 1'b1;
							end
						end
					end
					M_ATTR_VAL: begin
						if (c == (sq_q ? CH_SQ : CH_DQ)) begin
							e1 = mk(K_ATTR, start_q, p1 - start_q, aname_q, vorg_q, cnt_q);
							e1v = 1'b1;
							mode_d = M_IN_TAG;
						end else if (c == CH_LT) begin
							e2 = mk_err(E_LT_IN_VALUE, start_q, p - start_q);
							e2v = 1'b1;
						end else begin
							sc = cnt_q + CNT_BITS'(1);
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_VALUE_CAP, start_q, p1 - start_q);
								e2v = 1'b1;
							end
						end
					end
					M_RAW: begin
						if (prog_q < clen && lc == closer_ch(rawk_q, prog_q)) begin
							if (prog_q + 4'd1 < clen) prog_d = prog_q + 4'd1;
							else begin
								// closer complete: flush raw text, continue as close tag
								if (cnt_q != '0) begin
									e1 = mk(K_TEXT, start_q, POS_BITS'(cnt_q), '0, '0, '0);
									e1v = 1'b1;
								end
								start_d = cst;
								cnt_d = CNT_BITS'(clen) - CNT_BITS'(2);
								mode_d = M_CLOSE_NAME;
								rawk_d = RAW_NONE;
								prog_d = '0;
								if (CNT_BITS'(clen) - CNT_BITS'(2) > mt) begin
									e2 = mk_err(E_CLOSE_NAME_CAP, cst, mtp + POS_BITS'(3));
									e2v = 1'b1;
								end
							end
						end else begin
							sc = cnt_q + CNT_BITS'(prog_q);
							if (c == CH_LT) prog_d = 4'd1;
							else begin
								sc = sc + CNT_BITS'(1);
								prog_d = '0;
							end
							cnt_d = sc;
							if (sc > mt) begin
								e2 = mk_err(E_RAW_CAP, start_q, mtp + POS_BITS'(1));
								e2v = 1'b1;
							end
						end
					end
					default: mode_d = M_TEXT_IDLE;
				endcase

				// inside an opening tag
				if (tag_do && !is_ws(c)) begin
					if (c == CH_GT) begin
						e2 = mk(K_OPEN_END, p, POS_BITS'(1), '0, '0, '0);
						e2v = 1'b1;
						if (tag_sm != 2'b00) begin
							rawk_d = raw_t'(tag_sm);
							mode_d = M_RAW;
							start_d = p1;
							cnt_d = '0;
							prog_d = '0;
						end else mode_d = M_TEXT_IDLE;
						match_d = '0;
					end else if (c == CH_SLASH) begin
						start_d = p;
						mode_d = M_SLASH;
					end else if (is_nstart(c)) begin
						start_d = p;
						cnt_d = CNT_BITS'(1);
						mode_d = M_ATTR_NAME;
						if (CNT_BITS'(1) > mt) begin
							e2 = mk_err(E_ATTR_NAME_CAP, p, POS_BITS'(1));
							e2v = 1'b1;
						end
					end else begin
						e2 = mk_err(E_NO_ATTR_NAME, p, '0);
						e2v = 1'b1;
					end
				end

				halt_d = e2v && e2.kind == K_ERROR;
				if (!halt_d) pos_d = p1;
			end
		end
	end

	// compaction of the two token slots toward the queue
	always_comb begin
		push0 = e1v || e2v;
		push1 = e1v && e2v;
		tok0 = e1v ? e1 : e2;
		tok1 = e2;
		tok0.last = !push1;
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT_IDLE;
			pos_q <= '0;
			start_q <= '0;
			vorg_q <= '0;
			cnt_q <= '0;
			aname_q <= '0;
			sq_q <= 1'b0;
			match_q <= '0;
			dash_q <= '0;
			rawk_q <= RAW_NONE;
			prog_q <= '0;
			halt_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			start_q <= start_d;
			vorg_q <= vorg_d;
			cnt_q <= cnt_d;
			aname_q <= aname_d;
			sq_q <= sq_d;
			match_q <= match_d;
			dash_q <= dash_d;
			rawk_q <= rawk_d;
			prog_q <= prog_d;
			halt_q <= halt_d;
		end
	end

`ifndef SYNTHESIS
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !end_marker && halt_q) |-> !push0)
		else $error("token produced while halted on error");
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> accept)
		else $error("token produced without a request");
`endif

endmodule

[src/mbt_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbt_queue
// short token queue: takes up to two tokens per cycle, hands out one
// ---------------------------------------------------------------------------
module mbt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push0,
	input  logic          push1,
	input  mbt_pkg::tok_t tok0,
	input  mbt_pkg::tok_t tok1,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output mbt_pkg::tok_t head
);
	import mbt_pkg::*;

	tok_t               mem_q [QDEPTH];
	logic [QA_BITS-1:0] wr_q, rd_q;
	logic [QA_BITS:0]   cnt_q;
	logic               pop;
	logic [1:0]         nwr;

	assign out_valid = cnt_q != '0;
	assign pop = out_valid && out_ready;
	assign room = cnt_q <= (QA_BITS+1)'(QDEPTH - 2);
	assign head = mem_q[rd_q];
	assign nwr = {1'b0, push0} + {1'b0, push1};

	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q] <= tok0;
		if (push1) mem_q[wr_q + QA_BITS'(1)] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + QA_BITS'(nwr);
			if (pop) rd_q <= rd_q + QA_BITS'(1);
			cnt_q <= cnt_q + (QA_BITS+1)'(nwr) - (QA_BITS+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push0 |-> cnt_q <= (QA_BITS+1)'(QDEPTH - 2))
		else $error("token queue overflow");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |-> push0)
		else $error("second token slot used alone");
`endif

endmodule

[src/markup_byte_tokenizer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// markup_byte_tokenizer
// markup document tokenizer, one byte per clock, span-encoded tokens
// ---------------------------------------------------------------------------
// The block takes one byte request per clock (in_valid/in_ready) while the
// queue has room and scans it; every byte or end marker yields zero, one or
// two tokens, which enter a four-entry token queue and leave it one per clock
// on the out_valid/out_ready side. in_ready is low while fewer than two queue
// entries are free, so the sustained rate is one byte per clock as long as
// tokens are drained; a request that closes two tokens at once (a tag name
// ending in '>', a text run ended by the end marker) queues both together.
// The caps max_token_bytes (0x0) and max_input_bytes (0x4) are written over
// the APB port; the user must write them only while the block is idle, which
// the block does not enforce. After an error token the block drops bytes
// until the end marker, which always resets the document offset.
// ---------------------------------------------------------------------------
module markup_byte_tokenizer #(
	parameter int OFFSET_BITS = mbt_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = mbt_pkg::LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// byte requests
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             byte_value,
	input  logic                   end_marker,
	// token requests
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             token_kind,
	output logic [OFFSET_BITS-1:0] token_start,
	output logic [OFFSET_BITS-1:0] token_length,
	output logic [LENGTH_BITS-1:0] name_length,
	output logic [OFFSET_BITS-1:0] value_offset,
	output logic [LENGTH_BITS-1:0] value_length,
	output logic [4:0]             error_code,
	output logic                   last_of_run
);
	import mbt_pkg::*;

	caps_t caps_q;
	logic  push0, push1, room;
	tok_t  tok0, tok1, head;

	// register file: always ready, write on the access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_INPUT) ? 32'(caps_q.max_doc) : 32'(caps_q.max_tok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caps_q.max_tok <= TOK_CAP_RESET;
			caps_q.max_doc <= DOC_CAP_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MAX_INPUT) caps_q.max_doc <= pwdata[DOC_BITS-1:0];
			else caps_q.max_tok <= pwdata[TOK_BITS-1:0];
		end
	end

	// front: scanner state machine
	mbt_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.end_marker (end_marker),
		.caps       (caps_q),
		.room       (room),
		.push0      (push0),
		.push1      (push1),
		.tok0       (tok0),
		.tok1       (tok1)
	);

	// back: token queue feeding the output side
	mbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.push1     (push1),
		.tok0      (tok0),
		.tok1      (tok1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// spans are kept at full document width inside, cut to port width here
	assign token_kind   = head.kind;
	assign token_start  = OFFSET_BITS'(head.start);
	assign token_length = OFFSET_BITS'(head.len);
	assign name_length  = LENGTH_BITS'(head.nlen);
	assign value_offset = OFFSET_BITS'(head.vstart);
	assign value_length = LENGTH_BITS'(head.vlen);
	assign error_code   = head.code;
	assign last_of_run  = head.last;

endmodule

[dv/markup_byte_tokenizer_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// markup_byte_tokenizer_test
// self-checking bench: byte requests in, span tokens out, checked in order
// ---------------------------------------------------------------------------
// Documents are built from markup fragments (text, comments, tags with quoted
// attributes, style/script raw sections, close tags) mixed with stray bytes
// and ended by an end marker. A predictor in this file tracks the scanner
// state for every accepted byte request and queues the tokens it must emit;
// the monitor compares every delivered token field by field. Both sides idle
// at random, and the run steps through several cap settings.
// ---------------------------------------------------------------------------
module markup_byte_tokenizer_test;
	import mbt_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [2:0]  ADDR_TOK_CAP = 3'd0;
	localparam logic [2:0]  ADDR_DOC_CAP = 3'd4;
	// non-error tokens carry a zero code
	localparam err_t        NO_ERR       = E_INPUT_CAP;

	typedef struct packed {
		logic [7:0] b;
		logic       endm;
	} doc_item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [20:0] start;
		logic [20:0] len;
		logic [16:0] nlen;
		logic [20:0] vstart;
		logic [16:0] vlen;
		logic [4:0]  code;
		logic        last;
	} token_rec_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [7:0]  byte_value;
	logic        end_marker;
	logic        out_valid, out_ready;
	logic [3:0]  token_kind;
	logic [20:0] token_start, token_length, value_offset;
	logic [16:0] name_length, value_length;
	logic [4:0]  error_code;
	logic        last_of_run;

	markup_byte_tokenizer uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.byte_value(byte_value), .end_marker(end_marker),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .token_start(token_start),
		.token_length(token_length), .name_length(name_length),
		.value_offset(value_offset), .value_length(value_length),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	always #10 clk = ~clk;

	// stimulus and expectation stores
	doc_item_t  pending_bytes[$];
	token_rec_t tokens_due[$];
	token_rec_t step_tokens[$];

	bit          rst_done;
	bit          burst;          // no idling on either side when set
	bit          byte_taken, token_taken;
	int          in_gap, out_stall;
	int unsigned cycles, fails, tokens_seen, error_tokens, docs_sent, bytes_sent;

	// predictor copy of caps and scanner state
	int unsigned tok_cap, doc_cap;
	mode_t       mode;
	int unsigned pos, sp_start, sp_cnt, an_len, v_org, cl_prog, dashes;
	bit          sq, halted;
	logic [1:0]  name_hits;      // bit0 still "style", bit1 still "script"
	raw_t        raw_kind;

	function automatic bit is_space(logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic bit name_first(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic bit name_char(logic [7:0] c);
		return name_first(c) || (c >= "0" && c <= "9") || c == CH_DASH;
	endfunction

	function automatic logic [7:0] fold(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] closer_at(raw_t k, int unsigned i);
		string s;
		s = (k == RAW_SCRIPT) ? "</script" : "</style";
		return s[i];
	endfunction

	function automatic void add_token(kind_t k, int unsigned st, int unsigned ln,
			int unsigned nl, int unsigned vs, int unsigned vl, err_t e);
		token_rec_t t;
		t.kind = k;
		t.start = st[20:0];
		t.len = ln[20:0];
		t.nlen = nl[16:0];
		t.vstart = vs[20:0];
		t.vlen = vl[16:0];
		t.code = e;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void flag(err_t e, int unsigned st, int unsigned ln);
		halted = 1;
		add_token(K_ERROR, st, ln, 0, 0, 0, e);
	endfunction

	function automatic void clear_doc();
		mode = M_TEXT_IDLE;
		pos = 0; sp_start = 0; sp_cnt = 0; an_len = 0; v_org = 0;
		sq = 0; name_hits = 2'b00; raw_kind = RAW_NONE; cl_prog = 0;
		dashes = 0; halted = 0;
	endfunction

	function automatic void track_name(logic [7:0] c, int unsigned idx);
		string sw, cw;
		sw = "style";
		cw = "script";
		if (idx >= 5 || fold(c) != sw[idx]) name_hits[0] = 1'b0;
		if (idx >= 6 || fold(c) != cw[idx]) name_hits[1] = 1'b0;
	endfunction

	function automatic void tag_body(logic [7:0] c, int unsigned p);
		if (is_space(c)) return;
		if (c == CH_GT) begin
			add_token(K_OPEN_END, p, 1, 0, 0, 0, NO_ERR);
			// style or script opening tag switches to raw text
			if (name_hits != 2'b00) begin
				raw_kind = raw_t'(name_hits);
				mode = M_RAW;
				sp_start = p + 1;
				sp_cnt = 0;
				cl_prog = 0;
			end else mode = M_TEXT_IDLE;
			name_hits = 2'b00;
		end else if (c == CH_SLASH) begin
			sp_start = p;
			mode = M_SLASH;
		end else if (name_first(c)) begin
			sp_start = p;
			sp_cnt = 1;
			mode = M_ATTR_NAME;
			if (sp_cnt > tok_cap) flag(E_ATTR_NAME_CAP, sp_start, sp_cnt);
		end else flag(E_NO_ATTR_NAME, p, 0);
	endfunction

	function automatic void close_tag(int unsigned p);
		mode = M_TEXT_IDLE;
		add_token(K_CLOSE, sp_start, p + 1 - sp_start, sp_cnt, 0, 0, NO_ERR);
	endfunction

	function automatic void raw_scan(logic [7:0] c, int unsigned p);
		int unsigned clen, k;
		clen = (raw_kind == RAW_SCRIPT) ? 8 : 7;
		k = cl_prog;
		if (k < clen && fold(c) == closer_at(raw_kind, k)) begin
			k++;
			if (k < clen) begin
				cl_prog = k;
				return;
			end
			// closer complete: flush raw text, continue as a close tag name
			if (sp_cnt > 0) add_token(K_TEXT, sp_start, sp_cnt, 0, 0, 0, NO_ERR);
			sp_start = p + 1 - clen;
			sp_cnt = clen - 2;
			mode = M_CLOSE_NAME;
			raw_kind = RAW_NONE;
			cl_prog = 0;
			if (sp_cnt > tok_cap) flag(E_CLOSE_NAME_CAP, sp_start, 3 + tok_cap);
			return;
		end
		// partial closer letters turn out to be content
		sp_cnt += k;
		if (c == CH_LT) cl_prog = 1;
		else begin
			sp_cnt++;
			cl_prog = 0;
		end
		if (sp_cnt > tok_cap) flag(E_RAW_CAP, sp_start, tok_cap + 1);
	endfunction

	function automatic void scan_byte(logic [7:0] c, int unsigned p);
		case (mode)
			M_TEXT_IDLE: begin
				sp_start = p;
				if (c == CH_LT) mode = M_LT;
				else begin
					sp_cnt = 1;
					mode = M_TEXT_RUN;
					if (sp_cnt > tok_cap) flag(E_TEXT_CAP, sp_start, sp_cnt);
				end
			end
			M_TEXT_RUN: begin
				if (c == CH_LT) begin
					add_token(K_TEXT, sp_start, sp_cnt, 0, 0, 0, NO_ERR);
					sp_start = p;
					mode = M_LT;
				end else begin
					sp_cnt++;
					if (sp_cnt > tok_cap) flag(E_TEXT_CAP, sp_start, sp_cnt);
				end
			end
			M_LT: begin
				if (c == CH_BANG) mode = M_BANG;
				else if (c == CH_SLASH) mode = M_CLOSE_START;
				else if (name_first(c)) begin
					name_hits = 2'b11;
					track_name(c, 0);
					sp_cnt = 1;
					mode = M_TAG_NAME;
					if (sp_cnt > tok_cap) flag(E_TAG_NAME_CAP, sp_start, 1 + sp_cnt);
				end else flag(E_BAD_LT, sp_start, 0);
			end
			M_BANG: begin
				if (c == CH_DASH) mode = M_BANG_DASH;
				else flag(E_BAD_LT, sp_start, 0);
			end
			M_BANG_DASH: begin
				if (c == CH_DASH) begin
					mode = M_COMMENT;
					v_org = p + 1;
					sp_cnt = 0;
					dashes = 0;
				end else flag(E_BAD_LT, sp_start, 0);
			end
			M_COMMENT: begin
				if (c == CH_GT && dashes == 2) begin
					add_token(K_COMMENT, sp_start, p + 1 - sp_start, 0, v_org, sp_cnt, NO_ERR);
					dashes = 0;
					mode = M_TEXT_IDLE;
				end else begin
					// up to two trailing dashes are held back as a possible closer
					if (c == CH_DASH) begin
						if (dashes < 2) dashes++;
						else sp_cnt++;
					end else begin
						sp_cnt += dashes + 1;
						dashes = 0;
					end
					if (sp_cnt > tok_cap) flag(E_COMMENT_CAP, sp_start, 5 + tok_cap);
				end
			end
			M_CLOSE_START: begin
				if (name_first(c)) begin
					sp_cnt = 1;
					mode = M_CLOSE_NAME;
					if (sp_cnt > tok_cap) flag(E_CLOSE_NAME_CAP, sp_start, 2 + sp_cnt);
				end else flag(E_CLOSE_NO_NAME, sp_start, 2);
			end
			M_CLOSE_NAME: begin
				if (name_char(c)) begin
					sp_cnt++;
					if (sp_cnt > tok_cap) flag(E_CLOSE_NAME_CAP, sp_start, 2 + sp_cnt);
				end else if (is_space(c)) mode = M_CLOSE_WS;
				else if (c == CH_GT) close_tag(p);
				else flag(E_CLOSE_NO_GT, sp_start, p - sp_start);
			end
			M_CLOSE_WS: begin
				if (c == CH_GT) close_tag(p);
				else if (!is_space(c)) flag(E_CLOSE_NO_GT, sp_start, p - sp_start);
			end
			M_TAG_NAME: begin
				if (name_char(c)) begin
					track_name(c, sp_cnt);
					sp_cnt++;
					if (sp_cnt > tok_cap) flag(E_TAG_NAME_CAP, sp_start, 1 + sp_cnt);
				end else begin
					add_token(K_OPEN_START, sp_start, 1 + sp_cnt, sp_cnt, 0, 0, NO_ERR);
					if (name_hits[0] && sp_cnt == 5) name_hits = 2'b01;
					else if (name_hits[1] && sp_cnt == 6) name_hits = 2'b10;
					else name_hits = 2'b00;
					mode = M_IN_TAG;
					tag_body(c, p);
				end
			end
			M_IN_TAG: tag_body(c, p);
			M_SLASH: begin
				if (c == CH_GT) begin
					add_token(K_SELF_CLOSE, sp_start, 2, 0, 0, 0, NO_ERR);
					name_hits = 2'b00;
					mode = M_TEXT_IDLE;
				end else flag(E_STRAY_SLASH, sp_start, 0);
			end
			M_ATTR_NAME: begin
				if (name_char(c)) begin
					sp_cnt++;
					if (sp_cnt > tok_cap) flag(E_ATTR_NAME_CAP, sp_start, sp_cnt);
				end else if (is_space(c) || c == CH_EQ) begin
					an_len = sp_cnt;
					mode = (c == CH_EQ) ? M_ATTR_EQ : M_ATTR_WS;
				end else flag(E_NO_EQ, sp_start, p - sp_start);
			end
			M_ATTR_WS: begin
				if (c == CH_EQ) mode = M_ATTR_EQ;
				else if (!is_space(c)) flag(E_NO_EQ, sp_start, p - sp_start);
			end
			M_ATTR_EQ: begin
				if (c == CH_DQ || c == CH_SQ) begin
					sq = (c == CH_SQ);
					v_org = p + 1;
					sp_cnt = 0;
					mode = M_ATTR_VAL;
				end else if (!is_space(c)) flag(E_NO_QUOTE, sp_start, p - sp_start);
			end
			M_ATTR_VAL: begin
				if (c == (sq ? CH_SQ : CH_DQ)) begin
					add_token(K_ATTR, sp_start, p + 1 - sp_start, an_len, v_org, sp_cnt, NO_ERR);
					mode = M_IN_TAG;
				end else if (c == CH_LT) flag(E_LT_IN_VALUE, sp_start, p - sp_start);
				else begin
					sp_cnt++;
					if (sp_cnt > tok_cap) flag(E_VALUE_CAP, sp_start, p + 1 - sp_start);
				end
			end
			M_RAW: raw_scan(c, p);
			default: mode = M_TEXT_IDLE;
		endcase
	endfunction

	function automatic void finish_doc(int unsigned p);
		case (mode)
			M_TEXT_RUN: begin
				add_token(K_TEXT, sp_start, sp_cnt, 0, 0, 0, NO_ERR);
				add_token(K_EOF, p, 0, 0, 0, 0, NO_ERR);
			end
			M_LT, M_BANG, M_BANG_DASH: flag(E_BAD_LT, sp_start, 0);
			M_COMMENT: begin
				if (sp_cnt + dashes > tok_cap) flag(E_COMMENT_CAP, sp_start, 5 + tok_cap);
				else flag(E_COMMENT_OPEN, sp_start, p - sp_start);
			end
			M_CLOSE_START: flag(E_CLOSE_NO_NAME, sp_start, 2);
			M_CLOSE_NAME, M_CLOSE_WS: flag(E_CLOSE_NO_GT, sp_start, p - sp_start);
			M_TAG_NAME: begin
				add_token(K_OPEN_START, sp_start, 1 + sp_cnt, sp_cnt, 0, 0, NO_ERR);
				flag(E_TAG_OPEN, p, 0);
			end
			M_IN_TAG: flag(E_TAG_OPEN, p, 0);
			M_SLASH: flag(E_STRAY_SLASH, sp_start, 0);
			M_ATTR_NAME, M_ATTR_WS: flag(E_NO_EQ, sp_start, p - sp_start);
			M_ATTR_EQ: flag(E_NO_QUOTE, sp_start, p - sp_start);
			M_ATTR_VAL: flag(E_VALUE_OPEN, sp_start, p - sp_start);
			M_RAW: begin
				if (sp_cnt + cl_prog > tok_cap) flag(E_RAW_CAP, sp_start, tok_cap + 1);
				else flag(E_RAW_OPEN, sp_start, p - sp_start);
			end
			default: add_token(K_EOF, p, 0, 0, 0, 0, NO_ERR);
		endcase
	endfunction

	// tokens that one accepted byte request must produce
	function automatic void tokenize_request(doc_item_t it);
		int unsigned p;
		p = pos;
		step_tokens.delete();
		if (it.endm) begin
			if (!halted) finish_doc(p);
			clear_doc();
		end else if (!halted) begin
			if (p >= doc_cap) flag(E_INPUT_CAP, 0, (p + 1 > 21'h1FFFFF) ? 21'h1FFFFF : p + 1);
			else begin
				scan_byte(it.b, p);
				if (!halted) pos = p + 1;
			end
		end
		if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
		foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
	endfunction

	function automatic void check_field(string fname, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", fname, exp_v, act_v);
			fails++;
		end
	endfunction

	// ---------------- document generation ----------------
	task automatic put_byte(logic [7:0] b);
		doc_item_t it;
		it.b = b;
		it.endm = 1'b0;
		pending_bytes.push_back(it);
	endtask

	task automatic put_str(string s);
		foreach (s[i]) put_byte(s[i]);
	endtask

	// end marker with a random ignored byte
	task automatic put_end();
		doc_item_t it;
		it.b = 8'($urandom_range(0, 255));
		it.endm = 1'b1;
		pending_bytes.push_back(it);
	endtask

	task automatic put_mixed_case(string s);
		foreach (s[i]) put_byte(($urandom_range(0, 1) && s[i] >= "a") ? s[i] - 8'd32 : s[i]);
	endtask

	task automatic put_name();
		string pool[6];
		int n;
		pool = '{"a", "div", "p_1", "styles", "scr", "Z-9"};
		if ($urandom_range(0, 1)) put_mixed_case(pool[$urandom_range(0, 5)]);
		else begin
			n = $urandom_range(1, 4);
			repeat (n) put_byte(8'("a" + $urandom_range(0, 25)));
		end
	endtask

	task automatic put_filler(int maxlen, string alphabet);
		int n;
		n = $urandom_range(0, maxlen);
		repeat (n) put_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
	endtask

	task automatic put_fragment();
		int n;
		logic [7:0] q;
		case ($urandom_range(0, 9))
			0, 1: begin
				put_byte("x");
				put_filler(6, "ab c1\t\n");
			end
			2: begin
				put_str("<!--");
				put_filler(6, "a--b>");
				put_str($urandom_range(0, 2) ? "-->" : "--->");
			end
			3, 4: begin
				put_byte(CH_LT);
				put_name();
				n = $urandom_range(0, 2);
				repeat (n) begin
					q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
					put_byte(" ");
					put_name();
					if ($urandom_range(0, 3) == 0) put_str(" = ");
					else put_byte(CH_EQ);
					put_byte(q);
					put_filler(5, "v'\"=/ 3");
					put_byte(q);
				end
				put_str($urandom_range(0, 3) ? ">" : " />");
			end
			5: begin
				put_str("</");
				put_name();
				put_str($urandom_range(0, 2) ? ">" : " >");
			end
			6, 7: begin
				// raw section: style or script with near-miss closers inside
				string w;
				w = $urandom_range(0, 1) ? "style" : "script";
				put_byte(CH_LT);
				put_mixed_case(w);
				put_byte(CH_GT);
				put_filler(4, "r<s/</st");
				if ($urandom_range(0, 2) == 0) put_str("</sty");
				put_filler(3, "tx");
				put_str("</");
				put_mixed_case(w);
				put_byte(CH_GT);
			end
			8: put_byte(8'($urandom_range(0, 255)));
			default: begin
				// broken piece: lone or odd markup starts
				string bad[5];
				bad = '{"<", "<!", "<!-x", "</ ", "<a b"};
				put_str(bad[$urandom_range(0, 4)]);
			end
		endcase
	endtask

	task automatic put_document();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) put_fragment();
		put_end();
		docs_sent++;
	endtask

	// ---------------- configuration ----------------
	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (pending_bytes.size() > 0 || in_valid || tokens_due.size() > 0) @(posedge clk);
		// bytes that close no token may still be inside the block
		repeat (20) @(posedge clk);
	endtask

	task automatic set_caps(int unsigned tcap, int unsigned dcap);
		wait_quiet();
		reg_write(ADDR_TOK_CAP, tcap);
		reg_write(ADDR_DOC_CAP, dcap);
		tok_cap = tcap & 32'h1FFFF;
		doc_cap = dcap & 32'h1FFFFF;
	endtask

	// ---------------- byte request driver ----------------
	always @(negedge clk) begin : drive_bytes
		logic nv;
		doc_item_t it;
		nv = in_valid;
		if (rst_done && (!in_valid || byte_taken)) begin
			nv = 1'b0;
			if (in_gap > 0) in_gap--;
			else if (pending_bytes.size() > 0) begin
				it = pending_bytes.pop_front();
				byte_value <= it.b;
				end_marker <= it.endm;
				nv = 1'b1;
				in_gap = burst ? 0 : $urandom_range(0, 14);
			end
		end
		in_valid <= nv;
	end

	// ---------------- token request receiver ----------------
	always @(negedge clk) begin
		if (token_taken) out_stall = burst ? 0 : $urandom_range(0, 14);
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else out_ready <= rst_done;
	end

	// ---------------- prediction, checking, watchdog ----------------
	always @(posedge clk) begin : monitor
		token_rec_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("markup_byte_tokenizer regression: fail");
			$finish;
		end
		token_taken = out_valid && out_ready;
		if (token_taken) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				$error("token with nothing expected: kind %0d start %0d", token_kind, token_start);
				fails++;
			end else begin
				e = tokens_due.pop_front();
				if (e.kind == K_ERROR) error_tokens++;
				check_field("token_kind", e.kind, token_kind);
				check_field("token_start", e.start, token_start);
				check_field("token_length", e.len, token_length);
				check_field("name_length", e.nlen, name_length);
				check_field("value_offset", e.vstart, value_offset);
				check_field("value_length", e.vlen, value_length);
				check_field("error_code", e.code, error_code);
				check_field("last_of_run", e.last, last_of_run);
			end
		end
		byte_taken = in_valid && in_ready;
		if (byte_taken) begin
			bytes_sent++;
			tokenize_request({byte_value, end_marker});
		end
	end

	// ---------------- run sequence ----------------
	initial begin
		int unsigned tcaps[7];
		int unsigned dcaps[7];
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; byte_value = '0; end_marker = 1'b0; out_ready = 1'b0;
		rst_done = 0; burst = 0; in_gap = 0; out_stall = 0;
		tok_cap = 65536; doc_cap = 1048576;
		clear_doc();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		rst_done = 1;

		// directed: attribute with single quotes, text, close, empty comment,
		// high and low byte values as text
		set_caps(65536, 1048576);
		put_str("<p a='1'>x</p>");
		put_end();
		put_str("<!---->");
		put_end();
		put_byte(8'hFF);
		put_byte(8'h00);
		put_end();

		// cap settings, extremes included; the zero token cap flags every non-empty span
		tcaps = '{4, 2, 7, 1, 65536, 0, 65536};
		dcaps = '{1048576, 30, 1, 12, 1048576, 1048576, 1048576};
		foreach (tcaps[ph]) begin
			set_caps(tcaps[ph], dcaps[ph]);
			burst = (ph == 4);
			while (pending_bytes.size() < ((tcaps[ph] < 2 || dcaps[ph] < 20) ? 60 : 120))
				put_document();
		end

		wait_quiet();
		$display("covered %0d documents, %0d byte requests, %0d tokens (%0d errors)",
			docs_sent, bytes_sent, tokens_seen, error_tokens);
		$display("over %0d cap settings with random idling on both sides", 8);
		if (fails == 0) $display("markup_byte_tokenizer regression: pass");
		else $display("markup_byte_tokenizer regression: fail");
		$finish;
	end

endmodule
